>>> src/assert_macros.svh
// assertion macros for the checker file
// needs nothing else; each macro takes a label, clock, active-low reset and two expressions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/skf_pkg.sv
// types and constants of the scalar kalman smoother
// used by the control rom, the sequencer, the datapath and the top level
package skf_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'b1;

	localparam logic [31:0] PROCESS_NOISE_RST = 32'd536871;
	localparam logic [31:0] MEASURE_NOISE_RST = 32'd5368709;

	// width of the noise and covariance terms, unsigned q4.28
	localparam int COV_W = 32;

	// operand chunk of the shared multiplier
	localparam int CHUNK_W = 17;

	// program addresses
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_WAIT     = 3'd0;
	localparam logic [STEP_W-1:0] STEP_PREP     = 3'd1;
	localparam logic [STEP_W-1:0] STEP_DIV      = 3'd2;
	localparam logic [STEP_W-1:0] STEP_LOAD_EST = 3'd3;
	localparam logic [STEP_W-1:0] STEP_MAC_EST  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_LOAD_COV = 3'd5;
	localparam logic [STEP_W-1:0] STEP_MAC_COV  = 3'd6;
	localparam logic [STEP_W-1:0] STEP_FINISH   = 3'd7;

	typedef enum logic [2:0] {
		OP_WAIT     = 3'd0,
		OP_PREP     = 3'd1,
		OP_DIV      = 3'd2,
		OP_LOAD_EST = 3'd3,
		OP_MAC      = 3'd4,
		OP_LOAD_COV = 3'd5,
		OP_FINISH   = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		COND_NONE     = 2'd0,
		COND_NO_INPUT = 2'd1,
		COND_CNT_NZ   = 2'd2,
		COND_OUT_BUSY = 2'd3
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic in_take;
		logic cnt_nz;
		logic out_busy;
	} skf_status_t;

endpackage

>>> src/skf_ucode_rom.sv
// control program of the smoother, one control word per step
// depends on skf_pkg
module skf_ucode_rom import skf_pkg::*; (
	input  logic [STEP_W-1:0] addr,
	output ctrl_word_t        word
);

	// the finish step falls through by address wrap back to the wait step
	always_comb begin
		unique case (addr)
			STEP_WAIT:     word = '{op: OP_WAIT,     cond: COND_NO_INPUT, target: STEP_WAIT};
			STEP_PREP:     word = '{op: OP_PREP,     cond: COND_NONE,     target: STEP_WAIT};
			STEP_DIV:      word = '{op: OP_DIV,      cond: COND_CNT_NZ,   target: STEP_DIV};
			STEP_LOAD_EST: word = '{op: OP_LOAD_EST, cond: COND_NONE,     target: STEP_WAIT};
			STEP_MAC_EST:  word = '{op: OP_MAC,      cond: COND_CNT_NZ,   target: STEP_MAC_EST};
			STEP_LOAD_COV: word = '{op: OP_LOAD_COV, cond: COND_NONE,     target: STEP_WAIT};
			STEP_MAC_COV:  word = '{op: OP_MAC,      cond: COND_CNT_NZ,   target: STEP_MAC_COV};
			STEP_FINISH:   word = '{op: OP_FINISH,   cond: COND_OUT_BUSY, target: STEP_FINISH};
			default:       word = '{op: OP_WAIT,     cond: COND_NO_INPUT, target: STEP_WAIT};
		endcase
	end

endmodule

>>> src/skf_sequencer.sv
// step counter with conditional jumps, reads the control rom
// depends on skf_pkg and skf_ucode_rom
module skf_sequencer import skf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  skf_status_t status,
	output ctrl_word_t  ctrl
);

	logic [STEP_W-1:0] pc_q;
	logic              jump;

	skf_ucode_rom u_rom (
		.addr(pc_q),
		.word(ctrl)
	);

	always_comb begin
		unique case (ctrl.cond)
			COND_NONE:     jump = 1'b0;
			COND_NO_INPUT: jump = !status.in_take;
			COND_CNT_NZ:   jump = status.cnt_nz;
			COND_OUT_BUSY: jump = status.out_busy;
			default:       jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
		end else if (jump) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + STEP_W'(1);
		end
	end

endmodule

>>> src/skf_datapath.sv
// datapath of the smoother: state, restoring divider, chunked multiplier, output register
// depends on skf_pkg; driven by the control word from skf_sequencer
module skf_datapath import skf_pkg::*; #(
	parameter int SAMPLE_WIDTH   = 32,
	parameter int GAIN_FRAC_BITS = 30
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_word_t              ctrl,
	output skf_status_t             status,
	input  logic [COV_W-1:0]        process_noise,
	input  logic [COV_W-1:0]        measure_noise,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SAMPLE_WIDTH-1:0] sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [SAMPLE_WIDTH-1:0] estimate,
	output logic [COV_W-1:0]        covariance
);

	localparam int SW     = SAMPLE_WIDTH;
	localparam int G      = GAIN_FRAC_BITS;
	localparam int MAG_W  = SW + 1;
	localparam int OPA_W  = (MAG_W > COV_W) ? MAG_W : COV_W;
	localparam int NC     = (OPA_W + CHUNK_W - 1) / CHUNK_W;
	localparam int AW     = NC * CHUNK_W;
	localparam int BW     = G + 1;
	localparam int ACC_W  = AW + BW;
	localparam int PROD_W = CHUNK_W + BW;
	localparam int DEN_W  = COV_W + 1;
	localparam int REM_W  = COV_W + 2;
	localparam int CNT_W  = $clog2(G + 1);
	localparam logic [BW-1:0] ONE = {1'b1, {G{1'b0}}};

	logic signed [SW-1:0] est_q;
	logic [COV_W-1:0]     cov_q;
	logic [SW-1:0]        sample_q;
	logic [COV_W-1:0]     pm_q;
	logic [DEN_W-1:0]     den_q;
	logic [REM_W-1:0]     rem_q;
	logic [BW-1:0]        quo_q;
	logic [BW-1:0]        k_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [AW-1:0]        a_q;
	logic [BW-1:0]        b_q;
	logic [ACC_W-1:0]     acc_q;
	logic                 neg_q;
	logic                 out_valid_q;
	logic [SW-1:0]        estimate_q;
	logic [COV_W-1:0]     covariance_q;

	logic                 in_take;
	logic                 out_busy;
	logic                 finish;
	logic [COV_W:0]       pm_sum;
	logic [COV_W-1:0]     pm_sat;
	logic [REM_W-1:0]     den_ext;
	logic                 div_ge;
	logic [REM_W-1:0]     rem_sub;
	logic [REM_W-1:0]     rem_sel;
	logic [MAG_W-1:0]     diff;
	logic [MAG_W-1:0]     mag;
	logic [BW-1:0]        gain;
	logic [PROD_W-1:0]    prod;
	logic [SW-1:0]        corr;
	logic [COV_W-1:0]     cov_new;

	assign in_stall = (ctrl.op != OP_WAIT);
	assign in_take  = in_valid && !in_stall;
	assign out_busy = out_valid_q && out_stall;
	assign finish   = (ctrl.op == OP_FINISH) && !out_busy;

	assign status = '{in_take: in_take, cnt_nz: (cnt_q != '0), out_busy: out_busy};

	// predicted covariance, saturated
	assign pm_sum = {1'b0, cov_q} + {1'b0, process_noise};
	assign pm_sat = pm_sum[COV_W] ? {COV_W{1'b1}} : pm_sum[COV_W-1:0];

	// one restoring step per cycle, remainder stays below the denominator
	assign den_ext = {1'b0, den_q};
	assign div_ge  = (rem_q >= den_ext);
	assign rem_sub = rem_q - den_ext;
	assign rem_sel = div_ge ? rem_sub : rem_q;

	assign diff = {sample_q[SW-1], sample_q} - {est_q[SW-1], est_q};
	assign mag  = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
	assign gain = (den_q == '0) ? '0 : quo_q;

	// top chunk first, accumulator shifted by one chunk each step
	assign prod    = a_q[AW-1 -: CHUNK_W] * b_q;
	assign corr    = acc_q[G +: SW];
	assign cov_new = acc_q[G +: COV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q       <= '0;
			cov_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == OP_LOAD_COV) begin
				est_q <= neg_q ? (est_q - corr) : (est_q + corr);
			end
			if (finish) begin
				cov_q       <= cov_new;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_WAIT: begin
				if (in_take) begin
					sample_q <= sample;
					pm_q     <= pm_sat;
				end
			end
			OP_PREP: begin
				den_q <= {1'b0, pm_q} + {1'b0, measure_noise};
				rem_q <= REM_W'(pm_q);
				quo_q <= '0;
				cnt_q <= CNT_W'(G);
			end
			OP_DIV: begin
				rem_q <= {rem_sel[REM_W-2:0], 1'b0};
				quo_q <= {quo_q[BW-2:0], div_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_LOAD_EST: begin
				k_q   <= gain;
				b_q   <= gain;
				neg_q <= diff[MAG_W-1];
				a_q   <= AW'(mag);
				acc_q <= '0;
				cnt_q <= CNT_W'(NC - 1);
			end
			OP_MAC: begin
				acc_q <= (acc_q << CHUNK_W) + ACC_W'(prod);
				a_q   <= a_q << CHUNK_W;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_LOAD_COV: begin
				a_q   <= AW'(pm_q);
				b_q   <= ONE - k_q;
				acc_q <= '0;
				cnt_q <= CNT_W'(NC - 1);
			end
			OP_FINISH: begin
				if (finish) begin
					estimate_q   <= est_q;
					covariance_q <= cov_new;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign estimate   = estimate_q;
	assign covariance = covariance_q;

endmodule

>>> src/scalar_kalman_smoother_top.sv
// top level of the scalar kalman smoother: configuration registers and block wiring
// depends on skf_pkg, skf_sequencer and skf_datapath
//
// usage
//   input channel: in_valid / in_stall / sample (signed q16.16); a sample is taken at a
//   clock edge with in_valid high and in_stall low. in_stall is high while a sample is
//   being worked on and low only in the wait step.
//   output channel: out_valid / out_stall / estimate / covariance; one result per sample,
//   held in an output register until taken with out_stall low.
//   config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready; index 0
//   is process_noise, index 1 is measure_noise (both unsigned q4.28). write only while idle.
//   sequence: a sample is worked through to the finish step before the wait step comes
//   back, so no new sample is taken before the previous one is through. the result shows
//   up in the cycle after the finish step. the gain divider retires one quotient bit a
//   cycle (GAIN_FRAC_BITS + 1 steps) and the shared 17-bit by (GAIN_FRAC_BITS + 1)-bit
//   multiplier one chunk a cycle.
//   stall: a result still waiting at the finish step holds the sequencer there until
//   the previous transaction is taken; in_stall stays high meanwhile.
//   reset: the internal estimate and covariance clear to zero, not the output registers;
//   noise registers to defaults, output valid drops, the sequencer to the wait step.
module scalar_kalman_smoother_top import skf_pkg::*; #(
	parameter int SAMPLE_WIDTH   = 32,
	parameter int GAIN_FRAC_BITS = 30
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [SAMPLE_WIDTH-1:0] sample,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [SAMPLE_WIDTH-1:0] estimate,
	output logic [COV_W-1:0]        covariance,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [COV_W-1:0]        cfg_data
);

	logic [COV_W-1:0] process_noise_q;
	logic [COV_W-1:0] measure_noise_q;
	ctrl_word_t       ctrl;
	skf_status_t      status;

	// configuration writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			process_noise_q <= PROCESS_NOISE_RST;
			measure_noise_q <= MEASURE_NOISE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PROCESS_NOISE: process_noise_q <= cfg_data;
				REG_MEASURE_NOISE: measure_noise_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// program counter and control rom
	skf_sequencer u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.status(status),
		.ctrl  (ctrl)
	);

	// estimate and covariance arithmetic, output register
	skf_datapath #(
		.SAMPLE_WIDTH  (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS(GAIN_FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.status       (status),
		.process_noise(process_noise_q),
		.measure_noise(measure_noise_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.estimate     (estimate),
		.covariance   (covariance)
	);

endmodule

>>> src/skf_checker.sv
// port-level checks of the scalar kalman smoother, bound to the top level
// depends on assert_macros.svh and scalar_kalman_smoother_top
`include "assert_macros.svh"

module skf_checker #(
	parameter int SAMPLE_WIDTH = 32
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [SAMPLE_WIDTH-1:0] estimate,
	input logic [31:0]             covariance
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// a stalled result transaction holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(estimate) && $stable(covariance))

	// a taken sample keeps the block busy in the next cycle
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_acc, in_stall)

	// no result can appear right after a sample is taken
	`ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_acc, !$rose(out_valid))

	// a fresh result coincides with the block being ready again
	`ASSERT_IMPLY(a_ready_with_result, clk, arst_n, $rose(out_valid), !in_stall)

endmodule

bind scalar_kalman_smoother_top skf_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_chk (.*);
